// ----- rtl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the substring match finder.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int TEXT_W      = 8;
  localparam int HIST_DEPTH  = 16;
  localparam int LEN_W       = 5;
  localparam int PAT_WORD_W  = 64;
  localparam int START_W     = 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               match;
    logic [START_W-1:0] start_index;
    logic               last;
  } result_t;

endpackage

// ----- rtl/smf_window.sv -----
// ----------------------------------------------------------------------------
// smf_window
// Text history, position and match spacing; single-pass window compare.
// ----------------------------------------------------------------------------
module smf_window #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [smf_pkg::TEXT_W-1:0]         text_byte,
  input  logic                               end_of_text,
  input  logic [smf_pkg::LEN_W-1:0]          pattern_length,
  input  logic [smf_pkg::PAT_WORD_W-1:0]     pattern_low,
  input  logic [smf_pkg::PAT_WORD_W-1:0]     pattern_high,
  output smf_pkg::result_t                   res
);

  localparam int LIM   = (MAX_PATTERN < smf_pkg::HIST_DEPTH) ? MAX_PATTERN
                                                             : smf_pkg::HIST_DEPTH;
  localparam int BSM_W = $clog2(MAX_PATTERN + 1);
  localparam int CW    = (BSM_W > smf_pkg::LEN_W) ? BSM_W : smf_pkg::LEN_W;
  localparam int PW1   = POSITION_BITS + 1;

  logic [smf_pkg::TEXT_W-1:0]  hist_r   [smf_pkg::HIST_DEPTH];
  logic [smf_pkg::TEXT_W-1:0]  hist_nxt [smf_pkg::HIST_DEPTH];
  logic [smf_pkg::TEXT_W-1:0]  win      [smf_pkg::HIST_DEPTH];
  logic [smf_pkg::TEXT_W-1:0]  pat      [smf_pkg::HIST_DEPTH];
  logic [POSITION_BITS-1:0]    pos_r, pos_nxt;
  logic [BSM_W-1:0]            bsm_r, bsm_nxt, bsm_inc;
  logic [smf_pkg::LEN_W-1:0]   m;
  logic [PW1-1:0]              pos_inc, start_full;
  logic                        all_eq, hit;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat[j]     = pattern_low[8*j +: 8];
      pat[j + 8] = pattern_high[8*j +: 8];
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      m = smf_pkg::LEN_W'(1);
    end else if (pattern_length > smf_pkg::LEN_W'(LIM)) begin
      m = smf_pkg::LEN_W'(LIM);
    end else begin
      m = pattern_length;
    end
  end

  // window with the new byte shifted in, newest first
  always_comb begin
    win[0] = text_byte;
    for (int k = 1; k < smf_pkg::HIST_DEPTH; k++) begin
      win[k] = hist_r[k-1];
    end
  end

  always_comb begin
    logic [smf_pkg::LEN_W-1:0] sel;
    all_eq = 1'b1;
    for (int k = 0; k < smf_pkg::HIST_DEPTH; k++) begin
      sel = m - smf_pkg::LEN_W'(1) - smf_pkg::LEN_W'(k);
      if ((smf_pkg::LEN_W'(k) < m) && (win[k] != pat[sel[3:0]])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign bsm_inc    = (bsm_r < BSM_W'(MAX_PATTERN)) ? bsm_r + BSM_W'(1) : bsm_r;
  assign pos_inc    = {1'b0, pos_r} + PW1'(1);
  assign start_full = pos_inc - PW1'(m);
  assign hit        = (pos_inc >= PW1'(m)) && (CW'(bsm_inc) >= CW'(m)) && all_eq;

  always_comb begin
    res.match       = hit;
    res.start_index = hit ? smf_pkg::START_W'(start_full) : '0;
    res.last        = end_of_text;
  end

  always_comb begin
    if (end_of_text) begin
      for (int k = 0; k < smf_pkg::HIST_DEPTH; k++) hist_nxt[k] = '0;
      pos_nxt = '0;
      bsm_nxt = BSM_W'(MAX_PATTERN);
    end else begin
      for (int k = 0; k < smf_pkg::HIST_DEPTH; k++) hist_nxt[k] = win[k];
      pos_nxt = (&pos_r) ? pos_r : pos_inc[POSITION_BITS-1:0];
      bsm_nxt = hit ? '0 : bsm_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < smf_pkg::HIST_DEPTH; k++) hist_r[k] <= '0;
      pos_r <= '0;
      bsm_r <= BSM_W'(MAX_PATTERN);
    end else if (accept) begin
      for (int k = 0; k < smf_pkg::HIST_DEPTH; k++) hist_r[k] <= hist_nxt[k];
      pos_r <= pos_nxt;
      bsm_r <= bsm_nxt;
    end
  end

endmodule

// ----- rtl/smf_out_buf.sv -----
// ----------------------------------------------------------------------------
// smf_out_buf
// Result register with a skid stage; stall toward the source is registered.
// ----------------------------------------------------------------------------
module smf_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  smf_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output smf_pkg::result_t out_data
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  smf_pkg::result_t out_data_r, out_data_nxt;
  smf_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/substring_match_finder.sv -----
// ----------------------------------------------------------------------------
// substring_match_finder
// Streaming search for non-overlapping occurrences of a pattern of up to
// 16 bytes in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one text byte per word plus an
//   end-of-text flag. Output channel (out_valid/out_stall) returns one word
//   per input word: match flag, start index of the occurrence ending at that
//   byte, and the end-of-text echo.
//   Configuration (cfg_we/cfg_index/cfg_wdata) sets pattern length and the
//   pattern bytes; write only while no words are in flight.
//   The result is registered in the result register, or in the skid stage if stalled.
//   Throughput: one word per cycle while in_stall is low, set by the
//   combinational window compare of up to 16 bytes between the history register and the result register.
//   Reset (synchronous, rst_n low): history cleared, position zero, no
//   recent match, pattern length 1, pattern bytes zero, both channels empty.
//   Receiver stall: the result register holds; one more word fits in the
//   skid stage, after which in_stall rises until the held word is taken.
//   End of text clears position and history for the next word.
// ----------------------------------------------------------------------------
module substring_match_finder #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [smf_pkg::TEXT_W-1:0]       in_text_byte,
  input  logic                             in_end_of_text,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_match,
  output logic [smf_pkg::START_W-1:0]      out_start_index,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [smf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smf_pkg::PAT_WORD_W-1:0]   cfg_wdata
);

  logic [smf_pkg::LEN_W-1:0]      pattern_length_r;
  logic [smf_pkg::PAT_WORD_W-1:0] pattern_low_r;
  logic [smf_pkg::PAT_WORD_W-1:0] pattern_high_r;
  logic                           accept;
  logic                           full;
  smf_pkg::result_t               res;
  smf_pkg::result_t               out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= smf_pkg::LEN_W'(1);
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
    end else if (cfg_we) begin
      unique case (smf_pkg::cfg_reg_t'(cfg_index))
        smf_pkg::REG_PATTERN_LENGTH: begin
          pattern_length_r <= cfg_wdata[smf_pkg::LEN_W-1:0];
        end
        smf_pkg::REG_PATTERN_LOW: begin
          pattern_low_r <= cfg_wdata;
        end
        smf_pkg::REG_PATTERN_HIGH: begin
          pattern_high_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  smf_window #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .text_byte      (in_text_byte),
    .end_of_text    (in_end_of_text),
    .pattern_length (pattern_length_r),
    .pattern_low    (pattern_low_r),
    .pattern_high   (pattern_high_r),
    .res            (res)
  );

  smf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_match       = out_data.match;
  assign out_start_index = out_data.start_index;
  assign out_last        = out_data.last;

endmodule

// ----- rtl/smf_checker.sv -----
// ----------------------------------------------------------------------------
// smf_checker
// Port-level checks of the substring match finder, bound to the top level.
// ----------------------------------------------------------------------------
module smf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // after an accepted word the output holds a valid word next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word not presented");

  // back-pressure only after the output was held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output stall");

  a_stall_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word dropped");

endmodule

bind substring_match_finder smf_checker u_smf_checker (.*);
